// ===== hdl/lssg_pkg.sv =====
// ----------------------------------------------------------------------------
// lssg_pkg
// Shared types and constants for the looping sample segment generator.
// ----------------------------------------------------------------------------
package lssg_pkg;

    localparam int FRAME_W = 24;
    localparam int ADDR_W  = 29;
    localparam int BPS_W   = 3;
    localparam int CH_W    = 4;
    localparam int BPF_W   = 7;

    localparam logic [2:0] REG_LOOP_ENABLE      = 3'd0;
    localparam logic [2:0] REG_LOOP_START_FRAME = 3'd1;
    localparam logic [2:0] REG_LOOP_END_FRAME   = 3'd2;
    localparam logic [2:0] REG_TOTAL_FRAMES     = 3'd3;
    localparam logic [2:0] REG_BYTES_PER_SAMPLE = 3'd4;
    localparam logic [2:0] REG_CHANNEL_COUNT    = 3'd5;

    localparam logic SEG_COPY = 1'b0;
    localparam logic SEG_ZERO = 1'b1;

    typedef enum logic [1:0] {
        JOB_SINGLE,
        JOB_FILL,
        JOB_LOOP
    } job_mode_t;

    typedef struct packed {
        logic               loop_enable;
        logic [FRAME_W-1:0] loop_start;
        logic [FRAME_W-1:0] loop_end;
        logic [FRAME_W-1:0] total_frames;
    } cfg_t;

    typedef struct packed {
        job_mode_t          mode;
        logic [FRAME_W-1:0] start;
        logic [FRAME_W-1:0] first;
        logic [FRAME_W-1:0] remaining;
        logic [FRAME_W-1:0] loop_start;
        logic [FRAME_W-1:0] span;
        logic [FRAME_W-1:0] next_frame;
    } job_t;

    typedef struct packed {
        logic               kind;
        logic [FRAME_W-1:0] src;
        logic [FRAME_W-1:0] dst;
        logic [FRAME_W-1:0] len;
        logic [FRAME_W-1:0] next_frame;
        logic               last;
        logic               truncated;
    } seg_t;

endpackage

// ===== hdl/lssg_front.sv =====
// ----------------------------------------------------------------------------
// lssg_front
// Request front end: take a request, work out the first copy and the kind
// of run that follows, and hand one job word to the queue.
// ----------------------------------------------------------------------------
module lssg_front #(
    parameter int FRAME_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lssg_pkg::FRAME_W-1:0]  start_frame,
    input  logic [lssg_pkg::FRAME_W-1:0]  frame_count,
    input  lssg_pkg::cfg_t                cfg,
    output logic                          job_valid,
    input  logic                          job_ready,
    output lssg_pkg::job_t                job
);

    localparam int FW = lssg_pkg::FRAME_W;
    localparam logic [FW-1:0] FRAME_MASK =
        (FRAME_BITS >= FW) ? {FW{1'b1}} : FW'((64'd1 << FRAME_BITS) - 64'd1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_CLASS,
        ST_PUSH
    } state_t;

    state_t         state_reg;
    logic [FW-1:0]  start_reg;
    logic [FW-1:0]  count_reg;
    logic [FW-1:0]  endp_reg;
    logic [FW-1:0]  ls_reg;
    logic           looping_reg;
    logic           lt_reg;
    logic [FW-1:0]  diff_reg;
    logic [FW-1:0]  sum_reg;
    lssg_pkg::job_t job_reg;

    logic [FW:0]    sum_next;
    logic           lt_next;
    logic [FW-1:0]  diff_next;
    logic           rem_pos;
    logic [FW-1:0]  first_next;
    logic [FW-1:0]  remaining_next;
    logic [FW-1:0]  span_next;
    logic           degen;
    lssg_pkg::job_t job_next;

    assign s_ready   = (state_reg == ST_IDLE);
    assign job_valid = (state_reg == ST_PUSH);
    assign job       = job_reg;

    always_comb begin
        sum_next  = {1'b0, start_reg} + {1'b0, count_reg};
        lt_next   = sum_next < {1'b0, endp_reg};
        diff_next = (start_reg >= endp_reg) ? '0 : endp_reg - start_reg;
    end

    always_comb begin
        rem_pos        = diff_reg < count_reg;
        first_next     = rem_pos ? diff_reg : count_reg;
        remaining_next = rem_pos ? count_reg - diff_reg : '0;
        span_next      = endp_reg - ls_reg;
        degen          = endp_reg <= ls_reg;

        job_next.start      = start_reg;
        job_next.first      = first_next;
        job_next.remaining  = remaining_next;
        job_next.loop_start = ls_reg;
        job_next.span       = span_next;
        priority if (lt_reg) begin
            job_next.mode       = lssg_pkg::JOB_SINGLE;
            job_next.first      = count_reg;
            job_next.remaining  = '0;
            job_next.next_frame = sum_reg;
        end else if (!looping_reg || (rem_pos && degen)) begin
            job_next.mode       = lssg_pkg::JOB_FILL;
            job_next.next_frame = endp_reg;
        end else if (!rem_pos) begin
            job_next.mode       = lssg_pkg::JOB_SINGLE;
            job_next.next_frame = ls_reg;
        end else begin
            job_next.mode       = lssg_pkg::JOB_LOOP;
            job_next.next_frame = ls_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        start_reg   <= start_frame & FRAME_MASK;
                        count_reg   <= frame_count & FRAME_MASK;
                        looping_reg <= cfg.loop_enable;
                        ls_reg      <= cfg.loop_start & FRAME_MASK;
                        endp_reg    <= (cfg.loop_enable ? cfg.loop_end : cfg.total_frames)
                                       & FRAME_MASK;
                        state_reg   <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    lt_reg    <= lt_next;
                    diff_reg  <= diff_next;
                    sum_reg   <= sum_next[FW-1:0];
                    state_reg <= ST_CLASS;
                end
                ST_CLASS: begin
                    job_reg   <= job_next;
                    state_reg <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (job_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/lssg_fifo.sv =====
// ----------------------------------------------------------------------------
// lssg_fifo
// Two-entry job queue between the front end and the segment sequencer.
// ----------------------------------------------------------------------------
module lssg_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  lssg_pkg::job_t in_job,
    output logic           out_valid,
    input  logic           out_ready,
    output lssg_pkg::job_t out_job
);

    lssg_pkg::job_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           push;
    logic           pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_job   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== hdl/lssg_seq.sv =====
// ----------------------------------------------------------------------------
// lssg_seq
// Segment sequencer: turn one job into segments, one per cycle unless
// stalled, wrapping the loop until the request is filled or the limit is hit.
// ----------------------------------------------------------------------------
module lssg_seq #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           job_valid,
    output logic           job_ready,
    input  lssg_pkg::job_t job,
    output logic           seg_valid,
    input  logic           seg_ready,
    output lssg_pkg::seg_t seg
);

    localparam int FW    = lssg_pkg::FRAME_W;
    localparam int CNT_W = $clog2(MAX_SEGMENTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_LOOP
    } state_t;

    state_t         state_reg;
    logic [FW-1:0]  pos_reg;
    logic [FW-1:0]  rem_reg;
    logic [FW-1:0]  ls_reg;
    logic [FW-1:0]  span_reg;
    logic [FW-1:0]  next_reg;
    logic [CNT_W-1:0] cnt_reg;
    lssg_pkg::seg_t seg_reg;
    logic           seg_valid_reg;

    logic           advance;
    logic [FW:0]    diff;
    logic           rem_le;
    logic [FW-1:0]  chunk;
    logic [FW-1:0]  rem_next;
    logic           at_limit;
    logic           loop_last;
    logic [FW-1:0]  loop_next_frame;

    assign advance   = !seg_valid_reg || seg_ready;
    assign job_ready = (state_reg == ST_IDLE) && advance;
    assign seg_valid = seg_valid_reg;
    assign seg       = seg_reg;

    always_comb begin
        diff            = {1'b0, rem_reg} - {1'b0, span_reg};
        rem_le          = diff[FW] || (diff[FW-1:0] == '0);
        chunk           = rem_le ? rem_reg : span_reg;
        rem_next        = rem_le ? '0 : diff[FW-1:0];
        at_limit        = (cnt_reg == CNT_W'(MAX_SEGMENTS - 1));
        loop_last       = rem_le || at_limit;
        loop_next_frame = diff[FW] ? ls_reg + chunk : ls_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            seg_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (advance) begin
                        seg_valid_reg <= job_valid;
                        if (job_valid) begin
                            seg_reg.kind       <= lssg_pkg::SEG_COPY;
                            seg_reg.src        <= job.start;
                            seg_reg.dst        <= '0;
                            seg_reg.len        <= job.first;
                            seg_reg.truncated  <= 1'b0;
                            seg_reg.last       <= (job.mode == lssg_pkg::JOB_SINGLE);
                            seg_reg.next_frame <= (job.mode == lssg_pkg::JOB_SINGLE)
                                                  ? job.next_frame : '0;
                            pos_reg  <= job.first;
                            rem_reg  <= job.remaining;
                            ls_reg   <= job.loop_start;
                            span_reg <= job.span;
                            next_reg <= job.next_frame;
                            cnt_reg  <= CNT_W'(1);
                            unique case (job.mode)
                                lssg_pkg::JOB_FILL: state_reg <= ST_FILL;
                                lssg_pkg::JOB_LOOP: state_reg <= ST_LOOP;
                                default:            state_reg <= ST_IDLE;
                            endcase
                        end
                    end
                end
                ST_FILL: begin
                    if (advance) begin
                        seg_valid_reg      <= 1'b1;
                        seg_reg.kind       <= lssg_pkg::SEG_ZERO;
                        seg_reg.src        <= '0;
                        seg_reg.dst        <= pos_reg;
                        seg_reg.len        <= rem_reg;
                        seg_reg.next_frame <= next_reg;
                        seg_reg.last       <= 1'b1;
                        seg_reg.truncated  <= 1'b0;
                        state_reg          <= ST_IDLE;
                    end
                end
                ST_LOOP: begin
                    if (advance) begin
                        seg_valid_reg      <= 1'b1;
                        seg_reg.kind       <= lssg_pkg::SEG_COPY;
                        seg_reg.src        <= ls_reg;
                        seg_reg.dst        <= pos_reg;
                        seg_reg.len        <= chunk;
                        seg_reg.next_frame <= loop_last ? loop_next_frame : '0;
                        seg_reg.last       <= loop_last;
                        seg_reg.truncated  <= loop_last && !rem_le;
                        rem_reg            <= rem_next;
                        pos_reg            <= pos_reg + chunk;
                        cnt_reg            <= cnt_reg + CNT_W'(1);
                        if (loop_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/lssg_scale.sv =====
// ----------------------------------------------------------------------------
// lssg_scale
// Output stage: scale frame values to bytes and hold the descriptor word
// for the result channel.
// ----------------------------------------------------------------------------
module lssg_scale (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         seg_valid,
    output logic                         seg_ready,
    input  lssg_pkg::seg_t               seg,
    input  logic [lssg_pkg::BPF_W-1:0]   bpf,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [111:0]                 m_tdata,
    output logic                         m_tuser,
    output logic                         m_tlast
);

    localparam int FW = lssg_pkg::FRAME_W;
    localparam int AW = lssg_pkg::ADDR_W;
    localparam int PW = FW + lssg_pkg::BPF_W;

    logic          m_valid_reg;
    logic [111:0]  data_reg;
    logic          user_reg;
    logic          last_reg;

    logic [PW-1:0] src_prod;
    logic [PW-1:0] dst_prod;
    logic [PW-1:0] len_prod;

    assign seg_ready = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = data_reg;
    assign m_tuser   = user_reg;
    assign m_tlast   = last_reg;

    always_comb begin
        src_prod = PW'(seg.src) * PW'(bpf);
        dst_prod = PW'(seg.dst) * PW'(bpf);
        len_prod = PW'(seg.len) * PW'(bpf);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (seg_ready) begin
            m_valid_reg <= seg_valid;
            if (seg_valid) begin
                data_reg <= {seg.truncated, seg.next_frame,
                             len_prod[AW-1:0], dst_prod[AW-1:0], src_prod[AW-1:0]};
                user_reg <= seg.kind;
                last_reg <= seg.last;
            end
        end
    end

endmodule

// ===== hdl/looping_sample_segment_gen_unit.sv =====
// ----------------------------------------------------------------------------
// looping_sample_segment_gen_unit
// The front end steps through its idle, calc, class and push states for each
// request and takes a new one only once it is back in idle; the sequencer
// emits one descriptor a cycle unless the output stalls.
// Reset: synchronous active-low aresetn clears all control state and loads
// the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module looping_sample_segment_gen_unit #(
    parameter int MAX_SEGMENTS = 64,
    parameter int FRAME_BITS   = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // start_frame, frame_count
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // source_byte_addr, dest_byte_offset, byte_length,
                                    // next_frame, truncated
    output logic         m_tuser,   // segment_kind
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int FW = lssg_pkg::FRAME_W;

    logic                        loop_enable_reg;
    logic [FW-1:0]               loop_start_reg;
    logic [FW-1:0]               loop_end_reg;
    logic [FW-1:0]               total_frames_reg;
    logic [lssg_pkg::BPS_W-1:0]  bps_reg;
    logic [lssg_pkg::CH_W-1:0]   ch_reg;
    logic [lssg_pkg::BPF_W-1:0]  bpf_reg;

    logic [2:0]     reg_index;
    logic           cfg_write;
    lssg_pkg::cfg_t cfg;

    logic           job_valid;
    logic           job_ready;
    lssg_pkg::job_t job;
    logic           q_valid;
    logic           q_ready;
    lssg_pkg::job_t q_job;
    logic           seg_valid;
    logic           seg_ready;
    lssg_pkg::seg_t seg;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    assign cfg.loop_enable  = loop_enable_reg;
    assign cfg.loop_start   = loop_start_reg;
    assign cfg.loop_end     = loop_end_reg;
    assign cfg.total_frames = total_frames_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_enable_reg  <= 1'b0;
            loop_start_reg   <= '0;
            loop_end_reg     <= '0;
            total_frames_reg <= '0;
            bps_reg          <= lssg_pkg::BPS_W'(2);
            ch_reg           <= lssg_pkg::CH_W'(2);
        end else if (cfg_write) begin
            unique case (reg_index)
                lssg_pkg::REG_LOOP_ENABLE:      loop_enable_reg  <= pwdata[0];
                lssg_pkg::REG_LOOP_START_FRAME: loop_start_reg   <= pwdata[FW-1:0];
                lssg_pkg::REG_LOOP_END_FRAME:   loop_end_reg     <= pwdata[FW-1:0];
                lssg_pkg::REG_TOTAL_FRAMES:     total_frames_reg <= pwdata[FW-1:0];
                lssg_pkg::REG_BYTES_PER_SAMPLE: bps_reg <= pwdata[lssg_pkg::BPS_W-1:0];
                lssg_pkg::REG_CHANNEL_COUNT:    ch_reg  <= pwdata[lssg_pkg::CH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        bpf_reg <= lssg_pkg::BPF_W'(bps_reg) * lssg_pkg::BPF_W'(ch_reg);
    end

    always_comb begin
        unique case (reg_index)
            lssg_pkg::REG_LOOP_ENABLE:      prdata = 32'(loop_enable_reg);
            lssg_pkg::REG_LOOP_START_FRAME: prdata = 32'(loop_start_reg);
            lssg_pkg::REG_LOOP_END_FRAME:   prdata = 32'(loop_end_reg);
            lssg_pkg::REG_TOTAL_FRAMES:     prdata = 32'(total_frames_reg);
            lssg_pkg::REG_BYTES_PER_SAMPLE: prdata = 32'(bps_reg);
            lssg_pkg::REG_CHANNEL_COUNT:    prdata = 32'(ch_reg);
            default:                        prdata = '0;
        endcase
    end

    lssg_front #(
        .FRAME_BITS (FRAME_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .start_frame (s_tdata[23:0]),
        .frame_count (s_tdata[47:24]),
        .cfg         (cfg),
        .job_valid   (job_valid),
        .job_ready   (job_ready),
        .job         (job)
    );

    lssg_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (job_valid),
        .in_ready  (job_ready),
        .in_job    (job),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_job   (q_job)
    );

    lssg_seq #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg)
    );

    lssg_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg),
        .bpf       (bpf_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
